// File: hw/rtl/wmsr_pkg.sv
package wmsr_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = $clog2(DataW);
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 2;

  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  // Register indexes, taken from paddr[4:3]
  localparam logic [IdxW-1:0] RegModeIdx    = 2'd0;
  localparam logic [IdxW-1:0] RegModulusIdx = 2'd1;
  localparam logic [IdxW-1:0] RegWeightIdx  = 2'd2;

  localparam logic ModeWeighted = 1'b0;
  localparam logic ModeMax      = 1'b1;

  localparam logic [DataW-1:0] ModulusInit = DataW'(1);
  localparam logic [DataW-1:0] WeightInit  = DataW'(1);
  localparam logic [DataW-1:0] PowerInit   = DataW'(1);

  typedef struct packed {
    logic             mode;
    logic [DataW-1:0] modulus;
    logic [DataW-1:0] weight;
  } cfg_t;

  // One request to the shared modular step: (2r or r) + addend, mod q
  typedef struct packed {
    logic             dbl;
    logic [DataW-1:0] r;
    logic [DataW-1:0] addend;
  } step_req_t;

endpackage

// File: hw/rtl/wmsr_apb_regs.sv
module wmsr_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wmsr_pkg::AddrW-1:0] paddr,
  input  logic [wmsr_pkg::DataW-1:0] pwdata,
  output logic [wmsr_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output wmsr_pkg::cfg_t             cfg_o
);
  import wmsr_pkg::*;

  logic            wr_en;
  logic [IdxW-1:0] idx;
  cfg_t            cfg_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:AddrW-IdxW];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= ModeWeighted;
      cfg_q.modulus <= ModulusInit;
      cfg_q.weight  <= WeightInit;
    end else if (wr_en) begin
      unique case (idx)
        RegModeIdx:    cfg_q.mode    <= pwdata[0];
        RegModulusIdx: cfg_q.modulus <= pwdata;
        RegWeightIdx:  cfg_q.weight  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegModeIdx:    prdata = {{(DataW-1){1'b0}}, cfg_q.mode};
      RegModulusIdx: prdata = cfg_q.modulus;
      RegWeightIdx:  prdata = cfg_q.weight;
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/wmsr_modstep.sv
module wmsr_modstep (
  input  wmsr_pkg::step_req_t        req_i,
  input  logic [wmsr_pkg::DataW-1:0] modulus_i,
  output logic [wmsr_pkg::DataW-1:0] res_o
);
  import wmsr_pkg::*;

  localparam int unsigned SumW = DataW + 2;

  logic [SumW-1:0] base;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] q1;
  logic [SumW-1:0] q2;
  logic [SumW-1:0] d1;
  logic [SumW-1:0] d2;

  // Both operands sit below q, so the sum stays below 3q
  assign base = req_i.dbl ? {1'b0, req_i.r, 1'b0} : {2'b00, req_i.r};
  assign sum  = base + {2'b00, req_i.addend};
  assign q1   = {2'b00, modulus_i};
  assign q2   = {1'b0, modulus_i, 1'b0};
  assign d1   = sum - q1;
  assign d2   = sum - q2;

  always_comb begin
    priority if (modulus_i == '0) res_o = sum[DataW-1:0]; // modulus 2^64: wrap
    else if (sum >= q2)           res_o = d2[DataW-1:0];
    else if (sum >= q1)           res_o = d1[DataW-1:0];
    else                          res_o = sum[DataW-1:0];
  end

endmodule

// File: hw/rtl/wmsr_core.sv
module wmsr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wmsr_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wmsr_pkg::DataW-1:0] value_i,
  input  logic                       last_value_i,
  output logic                       emit_valid_o,
  input  logic                       emit_ready_i,
  output logic [wmsr_pkg::DataW-1:0] emit_data_o
);
  import wmsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHKP,
    S_REDP,
    S_MULT,
    S_REDT,
    S_ADDT,
    S_MULW,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [DataW-1:0] total_q, total_d;
  logic [DataW-1:0] power_q, power_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] term_q, term_d;
  logic [DataW-1:0] val_q, val_d;
  logic             last_q, last_d;

  step_req_t        step_req;
  logic [DataW-1:0] step_res;
  logic             x_msb;

  function automatic logic need_red(input logic [DataW-1:0] x, input logic [DataW-1:0] q);
    need_red = (q != '0) && (x >= q);
  endfunction

  wmsr_modstep u_step (
    .req_i     (step_req),
    .modulus_i (cfg_i.modulus),
    .res_o     (step_res)
  );

  assign x_msb        = x_q[DataW-1];
  assign in_stall_o   = (state_q != S_IDLE);
  assign emit_valid_o = (state_q == S_EMIT);
  assign emit_data_o  = total_q;

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    power_d = power_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    term_d  = term_q;
    val_d   = val_q;
    last_d  = last_q;

    step_req.dbl    = 1'b1;
    step_req.r      = acc_q;
    step_req.addend = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d  = value_i;
          last_d = last_value_i;
          if (cfg_i.mode == ModeMax) begin
            if (value_i > total_q) total_d = value_i;
            state_d = last_value_i ? S_EMIT : S_IDLE;
          end else begin
            state_d = S_CHKP;
          end
        end
      end
      S_CHKP: begin
        cnt_d = '0;
        acc_d = '0;
        if (need_red(power_q, cfg_i.modulus)) begin
          x_d     = power_q;
          state_d = S_REDP;
        end else begin
          x_d     = val_q;
          state_d = S_MULT;
        end
      end
      S_REDP: begin
        // shift one bit of power into the remainder
        step_req.addend = {{(DataW-1){1'b0}}, x_msb};
        acc_d = step_res;
        x_d   = x_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          power_d = step_res;
          acc_d   = '0;
          x_d     = val_q;
          state_d = S_MULT;
        end
      end
      S_MULT: begin
        // term = power * value mod q, value bits MSB first
        step_req.addend = x_msb ? power_q : '0;
        acc_d = step_res;
        x_d   = x_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          term_d = step_res;
          acc_d  = '0;
          if (need_red(total_q, cfg_i.modulus)) begin
            x_d     = total_q;
            state_d = S_REDT;
          end else begin
            state_d = S_ADDT;
          end
        end
      end
      S_REDT: begin
        step_req.addend = {{(DataW-1){1'b0}}, x_msb};
        acc_d = step_res;
        x_d   = x_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          total_d = step_res;
          state_d = S_ADDT;
        end
      end
      S_ADDT: begin
        step_req.dbl    = 1'b0;
        step_req.r      = total_q;
        step_req.addend = term_q;
        total_d = step_res;
        acc_d   = '0;
        x_d     = cfg_i.weight;
        cnt_d   = '0;
        state_d = S_MULW;
      end
      S_MULW: begin
        // advance power: power * w mod q
        step_req.addend = x_msb ? power_q : '0;
        acc_d = step_res;
        x_d   = x_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          power_d = step_res;
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_ready_i) begin
          total_d = '0;
          power_d = PowerInit;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      power_q <= PowerInit;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      power_q <= power_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    x_q    <= x_d;
    term_q <= term_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

endmodule

// File: hw/rtl/weighted_mod_sum_and_max_reducer_unit.sv
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_stall_o    value_i, last_value_i
// output    out        out_valid_o / out_stall_i  reduced_o
// config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// Max mode: one beat per cycle while no result waits. Weighted mode: two
// 64-step passes of the shared modular double-and-add unit per beat, and
// one more 64-step pass each for a power or total at or above q; the input
// stalls until they end. A last beat hands its result to the output register
// via the emit state, which holds while that register is full and stalled.
// Reset clears the config to mode 0, q = 1, w = 1, total 0 and power 1.
module weighted_mod_sum_and_max_reducer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wmsr_pkg::DataW-1:0] value_i,
  input  logic                       last_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wmsr_pkg::DataW-1:0] reduced_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wmsr_pkg::AddrW-1:0] paddr,
  input  logic [wmsr_pkg::DataW-1:0] pwdata,
  output logic [wmsr_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import wmsr_pkg::*;

  cfg_t             cfg;
  logic             emit_valid;
  logic             emit_ready;
  logic [DataW-1:0] emit_data;
  logic             out_valid_q;
  logic [DataW-1:0] reduced_q;

  wmsr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wmsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .last_value_i (last_value_i),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_data_o  (emit_data)
  );

  assign emit_ready  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign reduced_o   = reduced_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) reduced_q <= emit_data;
  end

  // a taken weighted beat locks the input side for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cfg.mode == ModeWeighted) |=> in_stall_o)
    else $error("input not held after weighted beat");

  // a blocked result stays pending in the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid && !emit_ready) |=> emit_valid)
    else $error("result dropped while output register full");

  // a new output beat comes only from a core result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(emit_valid))
    else $error("output valid without core result");

  // a result taken from the core is loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid && emit_ready) |=> out_valid_o)
    else $error("result not loaded into output register");

endmodule

// File: tb/testbench.sv
typedef logic [wmsr_pkg::DataW-1:0] word_t;

class reduction_scoreboard;
  word_t       pending_reduced[$];
  logic        mode;
  word_t       modulus;
  word_t       weight;
  word_t       total;
  word_t       power;
  int unsigned mismatches;

  function new();
    mode       = wmsr_pkg::ModeWeighted;
    modulus    = wmsr_pkg::ModulusInit;
    weight     = wmsr_pkg::WeightInit;
    total      = '0;
    power      = wmsr_pkg::PowerInit;
    mismatches = 0;
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  function void set_reg(logic [wmsr_pkg::IdxW-1:0] idx, word_t data);
    case (idx)
      wmsr_pkg::RegModeIdx:    mode = data[0];
      wmsr_pkg::RegModulusIdx: modulus = data;
      wmsr_pkg::RegWeightIdx:  weight = data;
      default: ;
    endcase
  endfunction

  // q = 0 stands for 2^64: plain wrap
  function word_t wrap_mod(word_t x);
    return (modulus == '0) ? x : x % modulus;
  endfunction

  function word_t scale_mod(word_t a, word_t b);
    logic [2*wmsr_pkg::DataW-1:0] prod;
    logic [2*wmsr_pkg::DataW-1:0] q_wide;
    prod   = {{wmsr_pkg::DataW{1'b0}}, a} * {{wmsr_pkg::DataW{1'b0}}, b};
    q_wide = {{wmsr_pkg::DataW{1'b0}}, modulus};
    if (modulus != '0) begin
      prod = prod % q_wide;
    end
    return prod[wmsr_pkg::DataW-1:0];
  endfunction

  // both operands already below q, q nonzero
  function word_t sum_mod(word_t x, word_t y);
    logic [wmsr_pkg::DataW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, modulus}) begin
      s = s - {1'b0, modulus};
    end
    return s[wmsr_pkg::DataW-1:0];
  endfunction

  function void note_value(word_t v, logic last);
    word_t term;
    if (mode == wmsr_pkg::ModeMax) begin
      if (v > total) begin
        total = v;
      end
    end else begin
      term = scale_mod(wrap_mod(v), power);
      if (modulus == '0) begin
        total = total + term;
      end else begin
        total = sum_mod(wrap_mod(total), term);
      end
      power = scale_mod(power, wrap_mod(weight));
    end
    if (last) begin
      pending_reduced.push_back(total);
      total = '0;
      power = wmsr_pkg::PowerInit;
    end
  endfunction

  function void check_reduced(word_t got);
    word_t want;
    if (pending_reduced.size() == 0) begin
      report($sformatf("reduced %h with no result pending", got));
    end else begin
      want = pending_reduced.pop_front();
      if (got !== want) begin
        report($sformatf("reduced %h, expected %h", got, want));
      end
    end
  endfunction
endclass

module testbench;
  import wmsr_pkg::*;

  localparam int unsigned SettleCycles = 300;
  localparam int unsigned QuietLimit   = 20000;
  localparam int unsigned PhaseItems   = 102;
  localparam logic [IdxW-1:0] RegSpareIdx = 2'd3;
  localparam word_t AllOnes = '1;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  word_t            value_i;
  logic             last_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  word_t            reduced_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  word_t            pwdata;
  word_t            prdata;
  logic             pready;

  reduction_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  weighted_mod_sum_and_max_reducer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .last_value_i (last_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reduced_o    (reduced_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_value(value_i, last_value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_reduced(reduced_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("[weighted_mod_sum_and_max_reducer_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(input word_t v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    last_value_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_reduced.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // drain, then give a beat with no result time to finish
  task automatic wait_idle();
    hold_for_results();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input word_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic mode, input word_t q, input word_t w);
    wait_idle();
    write_reg(RegModeIdx, word_t'(mode));
    write_reg(RegModulusIdx, q);
    write_reg(RegWeightIdx, w);
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 69; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 69; end
      default: begin send_idle_pct = 8; stall_pct = 8; end
    endcase
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t draw_value();
    word_t q;
    q = sb.modulus;
    case ($urandom_range(7))
      0: return AllOnes;
      1: return '0;
      2: return word_t'($urandom_range(255));
      3: return (q == '0) ? AllOnes : q - 1;
      4: return q;
      default: return rand_word();
    endcase
  endfunction

  task automatic run_phase(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(29) == 0) begin
        hold_for_results();
      end
      len = ($urandom_range(15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
        send_beat(draw_value(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    last_value_i = 1'b0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet_cycles = 0;
    set_idling(0);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: q = 1, so every weighted result is zero
    send_beat(AllOnes, 1'b0);
    send_beat('0, 1'b1);

    // q = 0 acts as 2^64
    apply_setting(ModeWeighted, '0, AllOnes);
    send_beat(AllOnes, 1'b0);
    send_beat(AllOnes, 1'b0);
    send_beat(64'h8000_0000_0000_0001, 1'b1);

    apply_setting(ModeWeighted, AllOnes, 64'd2);
    send_beat(AllOnes, 1'b0);
    send_beat(AllOnes - 1, 1'b0);
    send_beat(AllOnes, 1'b1);

    apply_setting(ModeWeighted, 64'd1000003, '0);
    send_beat(rand_word(), 1'b0);
    send_beat(rand_word(), 1'b0);
    send_beat(64'd1000003, 1'b1);

    apply_setting(ModeMax, 64'd1000003, '0);
    send_beat('0, 1'b1);
    send_beat(AllOnes, 1'b0);
    send_beat(64'd5, 1'b1);

    // switch to max with a weighted total still open
    apply_setting(ModeWeighted, 64'd97, 64'd3);
    send_beat(rand_word(), 1'b0);
    send_beat(rand_word(), 1'b0);
    wait_idle();
    write_reg(RegModeIdx, word_t'(ModeMax));
    send_beat(64'd50, 1'b1);

    // and back: a max total above q gets folded in
    send_beat(64'h8000_0000_0000_0005, 1'b0);
    wait_idle();
    write_reg(RegModeIdx, word_t'(ModeWeighted));
    send_beat(64'd1, 1'b1);

    // shrink q mid-run, leaving power above it
    apply_setting(ModeWeighted, 64'h0000_0100_0000_000f, AllOnes);
    send_beat(rand_word(), 1'b0);
    send_beat(rand_word(), 1'b0);
    wait_idle();
    write_reg(RegModulusIdx, 64'd13);
    send_beat(rand_word(), 1'b1);

    // unmapped register: must not disturb anything
    wait_idle();
    write_reg(RegSpareIdx, rand_word());
    send_beat(64'd7, 1'b1);
    hold_for_results();

    for (int unsigned p = 0; p < 12; p++) begin
      case (p)
        0, 10:   apply_setting(ModeWeighted, rand_word(), rand_word());
        1, 5, 9: apply_setting(ModeMax, rand_word(), rand_word());
        2:       apply_setting(ModeWeighted, '0, rand_word());
        3:       apply_setting(ModeWeighted, AllOnes, AllOnes);
        4:       apply_setting(ModeWeighted, word_t'($urandom_range(1, 16)), rand_word());
        6:       apply_setting(ModeWeighted, word_t'($urandom), '0);
        7:       apply_setting(ModeWeighted, 64'd1, rand_word());
        8:       apply_setting(ModeWeighted, rand_word(), 64'd1);
        default: apply_setting(ModeWeighted, 64'h8000_0000_0000_0000, rand_word());
      endcase
      set_idling(p);
      run_phase(PhaseItems);
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("[weighted_mod_sum_and_max_reducer_unit] OK");
    end else begin
      $display("[weighted_mod_sum_and_max_reducer_unit] ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/wmsr_pkg.sv
hw/rtl/wmsr_apb_regs.sv
hw/rtl/wmsr_modstep.sv
hw/rtl/wmsr_core.sv
hw/rtl/weighted_mod_sum_and_max_reducer_unit.sv
tb/testbench.sv
